>>> sv/eea_pkg.sv
// Package for the epoch ensemble averager.
// Holds command and status codes, fixed field widths and the accumulator control struct.
// No dependencies.
package eea_pkg;

  // Fixed field widths.
  localparam int CMD_W      = 2;
  localparam int CHANNEL_W  = 6;
  localparam int POSITION_W = 10;
  localparam int STATUS_W   = 2;
  localparam int CHAN_REG_W = 7;
  localparam int SAMP_REG_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOEP  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES  = 1'd1;
  localparam logic [CHAN_REG_W-1:0] CHAN_RESET = 7'd64;
  localparam logic [SAMP_REG_W-1:0] SAMP_RESET = 11'd1024;

  // Control of the accumulator memory for one item.
  typedef struct packed {
    logic rd;     // read the addressed sum
    logic wr;     // write back the updated sum
    logic first;  // no epoch complete yet: store the sample as is
  } acc_ctl_t;

endpackage

>>> sv/epoch_ensemble_averager.sv
// Top level of the epoch ensemble averager: command sequencer, epoch count,
// configuration registers and output register. Depends on eea_pkg, eea_accum, eea_div.
//
//  Port group   Handshake               Carries
//  in           in_valid / in_ready     cmd, channel, position, sample_value, epoch_end
//  out          out_valid / out_ready   mean_value, status, epochs_counted
//  cfg          cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An add does one memory read, then the write-back of the updated sum. A clear or an
// unused command finishes when accepted. A read with an index in range and at least
// one epoch waits for the bit-serial divider; a read that reports out of range or no
// epochs skips the divider.
// One item is in work at a time; the output register lets the next item enter
// while a result waits. Reset clears the epoch count and restores the
// configuration; the sum memory is not cleared. The config port is always ready.
module epoch_ensemble_averager #(
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_SAMPLES  = 1024,
  parameter int SAMPLE_BITS  = 24,
  parameter int COUNT_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [eea_pkg::CMD_W-1:0]           cmd,
  input  logic [eea_pkg::CHANNEL_W-1:0]       channel,
  input  logic [eea_pkg::POSITION_W-1:0]      position,
  input  logic signed [SAMPLE_BITS-1:0]       sample_value,
  input  logic                                epoch_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       mean_value,
  output logic [eea_pkg::STATUS_W-1:0]        status,
  output logic [COUNT_BITS-1:0]               epochs_counted,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [eea_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [eea_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import eea_pkg::*;

  localparam int ACC_BITS = SAMPLE_BITS + COUNT_BITS;
  localparam int DEPTH    = MAX_CHANNELS * MAX_SAMPLES;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                    state;
  logic [CMD_W-1:0]              op_cmd;
  logic                          op_in_range;
  logic                          op_end;
  logic signed [SAMPLE_BITS-1:0] op_sample;
  logic [COUNT_BITS-1:0]         cnt;
  logic [CHAN_REG_W-1:0]         chan_lim;
  logic [SAMP_REG_W-1:0]         samp_lim;
  logic signed [SAMPLE_BITS-1:0] res_mean;
  logic [STATUS_W-1:0]           res_status;

  logic                          accept;
  logic                          in_range;
  logic [AW-1:0]                 addr;
  acc_ctl_t                      acc_ctl;
  logic signed [ACC_BITS-1:0]    acc_rdata;
  logic                          div_start;
  logic                          div_done;
  logic signed [SAMPLE_BITS-1:0] div_quotient;
  logic                          out_load;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);

  // Index check against both the configured and the built-in limits.
  assign in_range = ({1'b0, channel} < chan_lim) && (32'(channel) < MAX_CHANNELS) &&
                    ({1'b0, position} < samp_lim) && (32'(position) < MAX_SAMPLES);
  assign addr = AW'(32'(channel) * MAX_SAMPLES + 32'(position));

  // Memory control: read on accept, write back in the following cycle.
  always_comb begin
    acc_ctl.rd    = accept;
    acc_ctl.wr    = (state == ST_LOOK) && (op_cmd == CMD_ADD) && op_in_range;
    acc_ctl.first = (cnt == '0);
  end

  assign div_start = (state == ST_LOOK) && (op_cmd == CMD_READ) && op_in_range && (cnt != '0);

  eea_accum #(
    .ACC_W   (ACC_BITS),
    .SAMPLE_W(SAMPLE_BITS),
    .DEPTH   (DEPTH),
    .AW      (AW)
  ) u_accum (
    .clk   (clk),
    .ctl   (acc_ctl),
    .addr  (addr),
    .sample(op_sample),
    .rdata (acc_rdata)
  );

  eea_div #(
    .DIVIDEND_W(ACC_BITS),
    .DIVISOR_W (COUNT_BITS),
    .RESULT_W  (SAMPLE_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acc_rdata),
    .divisor (cnt),
    .done    (div_done),
    .quotient(div_quotient)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_lim <= CHAN_RESET;
      samp_lim <= SAMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHANNELS: chan_lim <= cfg_data[CHAN_REG_W-1:0];
        CFG_SAMPLES:  samp_lim <= cfg_data[SAMP_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Item fields held while the item is in work.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd      <= cmd;
      op_in_range <= in_range;
      op_end      <= epoch_end;
      op_sample   <= sample_value;
    end
  end

  // Sequencer and epoch count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd == CMD_CLEAR) begin
              cnt <= '0;
            end else if (cmd inside {CMD_ADD, CMD_READ}) begin
              state <= ST_LOOK;
            end
          end
        end
        ST_LOOK: begin
          if (op_cmd == CMD_ADD) begin
            if (op_end && cnt != '1) begin
              cnt <= cnt + COUNT_BITS'(1);
            end
            state <= ST_IDLE;
          end else if (div_start) begin
            state <= ST_DIV;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result of a read, formed in the cycle after the memory read or at divider done.
  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      res_mean   <= '0;
      res_status <= !op_in_range ? STATUS_RANGE : STATUS_NOEP;
    end else if (state == ST_DIV && div_done) begin
      res_mean   <= div_quotient;
      res_status <= STATUS_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_value     <= res_mean;
      status         <= res_status;
      epochs_counted <= cnt;
    end
  end

  // The memory write-back always follows the read of the same item.
  a_look_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) |-> $past(accept))
    else $error("memory lookup without an accepted item");

  // The epoch count holds at its maximum unless cleared.
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    (cnt == '1) |=> (cnt == '1 || cnt == '0))
    else $error("epoch count wrapped");

  // The divider never runs on a zero count.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (cnt != '0 && state == ST_LOOK))
    else $error("division by a zero epoch count");

  // A successful result carries a nonzero epoch count.
  a_ok_has_epochs: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_OK) |-> (epochs_counted != '0))
    else $error("mean reported with no epochs");

endmodule

>>> sv/eea_accum.sv
// Accumulator store of the epoch ensemble averager.
// One synchronous memory of sums with a registered read and a saturating write-back.
// Depends on eea_pkg.
module eea_accum #(
  parameter int ACC_W    = 40,
  parameter int SAMPLE_W = 24,
  parameter int DEPTH    = 65536,
  parameter int AW       = 16
) (
  input  logic                       clk,
  input  eea_pkg::acc_ctl_t          ctl,
  input  logic [AW-1:0]              addr,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [ACC_W-1:0]    rdata
);
  import eea_pkg::*;

  logic signed [ACC_W-1:0] mem [DEPTH];
  logic [AW-1:0]           waddr;
  logic signed [ACC_W-1:0] sample_ext;
  logic signed [ACC_W:0]   sum_wide;
  logic signed [ACC_W-1:0] sum_sat;
  logic signed [ACC_W-1:0] wdata;

  // Sign-extend the sample and add it to the stored sum with one guard bit.
  assign sample_ext = {{(ACC_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
  assign sum_wide   = {rdata[ACC_W-1], rdata} + {sample_ext[ACC_W-1], sample_ext};

  // Clamp the sum when the guard bit disagrees with the sign bit.
  always_comb begin
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  assign wdata = ctl.first ? sample_ext : sum_sat;

  // Read port: latch the address for the write-back that follows.
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[addr];
      waddr <= addr;
    end
  end

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

>>> sv/eea_div.sv
// Sequential divider of the epoch ensemble averager.
// Signed sum by unsigned count, one quotient bit per cycle, truncated and clamped.
// Depends on eea_pkg.
module eea_div #(
  parameter int DIVIDEND_W = 40,
  parameter int DIVISOR_W  = 16,
  parameter int RESULT_W   = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic                         done,
  output logic signed [RESULT_W-1:0]   quotient
);
  import eea_pkg::*;

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);
  localparam logic [DIVIDEND_W-1:0] MAG_POS =
    DIVIDEND_W'((64'd1 << (RESULT_W - 1)) - 64'd1);
  localparam logic [DIVIDEND_W-1:0] MAG_NEG = MAG_POS + DIVIDEND_W'(1);

  logic                  busy;
  logic                  fin;
  logic                  neg;
  logic [STEP_W-1:0]     step;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    trial;
  logic                  take;
  logic [DIVISOR_W:0]    trial_sub;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial     = {rem, quo[DIVIDEND_W-1]};
  assign take      = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};

  // Control: busy for one step per dividend bit, then fin to sign and clamp and raise done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DIVIDEND_W);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitude, remainder and quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DIVIDEND_W-1];
      quo <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], take};
      rem <= take ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  // Apply the sign and clamp to the result range.
  always_ff @(posedge clk) begin
    if (fin) begin
      if (neg) begin
        quotient <= (quo > MAG_NEG) ? {1'b1, {(RESULT_W-1){1'b0}}}
                                    : RESULT_W'(-quo[RESULT_W-1:0]);
      end else begin
        quotient <= (quo > MAG_POS) ? {1'b0, {(RESULT_W-1){1'b1}}}
                                    : quo[RESULT_W-1:0];
      end
    end
  end

  // A new division never starts while one is running.
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    (busy || fin) |-> !start)
    else $error("divider restarted while busy");

endmodule
